### rtl/assert_macros.svh
// Assertion macros for the particle pool RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/ppu_pkg.sv
// Types, widths and constants of the particle pool update block.
package ppu_pkg;

	localparam int POOL_SLOTS = 64;
	localparam int ADDR_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
	localparam int SUM_W      = CNT_W + 1;

	localparam int ACT_W   = 7;
	localparam int SLOT_W  = 6;
	localparam int Q_W     = 17;
	localparam int P_W     = 24;
	localparam int DT_W    = 16;
	localparam int PROD_W  = P_W + DT_W + 1;

	localparam int IN_BITS  = 179;
	localparam int IN_W     = 184;
	localparam int OUT_BITS = 103;
	localparam int OUT_W    = 104;

	localparam logic [ACT_W-1:0] ACT_RESET = 7'd64;
	localparam logic [Q_W-1:0]   ONE_Q16   = 17'h10000;

	// x/10 as (x * recip) >> shift, exact over the operand ranges used
	localparam logic [15:0] JIT_RECIP   = 16'd52429;
	localparam int          JIT_SHIFT   = 19;
	localparam logic [23:0] TENTH_RECIP = 24'hCCCCCD;
	localparam int          TENTH_SHIFT = 27;
	localparam logic signed [PROD_W-1:0] HALF_STEP = 41'sd32768;

	typedef enum logic [1:0] {
		KIND_SPAWN = 2'd0,
		KIND_TICK  = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// first field sits in the high bits
	typedef struct packed {
		logic [5:0]        index;
		logic [6:0]        shade;
		logic [5:0]        jitter;
		logic signed [23:0] offset_y;
		logic signed [23:0] offset_x;
		logic signed [23:0] obj_vy;
		logic signed [23:0] obj_vx;
		logic signed [23:0] obj_y;
		logic signed [23:0] obj_x;
		logic [15:0]       dt;
	} in_item_t;

	typedef struct packed {
		logic [6:0]        live_count;
		logic [6:0]        grey;
		logic [16:0]       alpha;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_x;
		logic [16:0]       life_left;
		logic              live;
		logic [5:0]        slot;
	} out_item_t;

	typedef struct packed {
		logic [6:0]        shade;
		logic [16:0]       alpha;
		logic signed [23:0] vel_y;
		logic signed [23:0] vel_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_x;
		logic [16:0]       life;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		entry_t            data;
	} store_wr_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
		entry_t            data;
	} tick_req_t;

endpackage

### rtl/ppu_store.sv
// Slot memory with one read and one write port and per-slot valid bits.
module ppu_store import ppu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  store_wr_t         wr,
	output entry_t            rd_data
);

	entry_t            mem [POOL_SLOTS];
	entry_t            rd_q;
	logic [POOL_SLOTS-1:0] vld_q;
	logic              rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// a slot never written since reset reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

### rtl/ppu_spawn_calc.sv
// Spawn datapath: jitter and velocity scaling, then the new slot contents.
module ppu_spawn_calc import ppu_pkg::*; (
	input  logic     clk,
	input  in_item_t item,
	output entry_t   entry
);

	logic [13:0]        jit_num;
	logic [29:0]        jit_prod;
	logic [10:0]        jit_q;
	logic signed [23:0] velx_q;
	logic signed [23:0] vely_q;

	// round-to-nearest tenth, ties away from zero
	function automatic logic signed [23:0] tenth(input logic signed [23:0] v);
		logic [23:0] mag;
		logic [23:0] num;
		logic [47:0] prod;
		logic [23:0] q;
		mag  = v[23] ? 24'(-v) : 24'(v);
		num  = mag + 24'd5;
		prod = 48'(num) * 48'(TENTH_RECIP);
		q    = 24'(prod >> TENTH_SHIFT);
		return v[23] ? $signed(-q) : $signed(q);
	endfunction

	assign jit_num  = {item.jitter, 8'd0} + 14'd5;
	assign jit_prod = 30'(jit_num) * 30'(JIT_RECIP);

	always_ff @(posedge clk) begin
		jit_q  <= 11'(jit_prod >> JIT_SHIFT);
		velx_q <= tenth(item.obj_vx);
		vely_q <= tenth(item.obj_vy);
	end

	always_comb begin
		entry       = '0;
		entry.life  = ONE_Q16;
		entry.alpha = ONE_Q16;
		entry.pos_x = item.obj_x + $signed(24'(jit_q)) + item.offset_x;
		entry.pos_y = item.obj_y + $signed(24'(jit_q)) + item.offset_y;
		entry.vel_x = velx_q;
		entry.vel_y = vely_q;
		entry.shade = item.shade;
	end

endmodule

### rtl/ppu_tick_alu.sv
// Two-stage tick update: age, move and fade one slot per cycle.
module ppu_tick_alu import ppu_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [DT_W-1:0] dt,
	input  tick_req_t       req,
	output store_wr_t       wr,
	output logic            live
);

	logic [Q_W-1:0]            life_new;
	logic signed [PROD_W-1:0]  prodx;
	logic signed [PROD_W-1:0]  prody;
	logic                      v_s2;
	logic [ADDR_W-1:0]         addr_s2;
	entry_t                    entry_s2;
	logic [Q_W-1:0]            life_s2;
	logic signed [PROD_W-1:0]  prodx_s2;
	logic signed [PROD_W-1:0]  prody_s2;
	logic signed [PROD_W-1:0]  step_x;
	logic signed [PROD_W-1:0]  step_y;
	logic [17:0]               fade;
	logic                      alive;

	assign life_new = (req.data.life > Q_W'(dt)) ? req.data.life - Q_W'(dt) : '0;
	assign prodx    = PROD_W'(req.data.vel_x) * PROD_W'($signed({1'b0, dt}));
	assign prody    = PROD_W'(req.data.vel_y) * PROD_W'($signed({1'b0, dt}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2  <= req.addr;
		entry_s2 <= req.data;
		life_s2  <= life_new;
		prodx_s2 <= prodx;
		prody_s2 <= prody;
	end

	// floor of (v*dt + half) / 2^16
	assign step_x = (prodx_s2 + HALF_STEP) >>> 16;
	assign step_y = (prody_s2 + HALF_STEP) >>> 16;
	assign fade   = 18'((19'(dt) * 19'd5 + 19'd1) >> 1);
	assign alive  = (life_s2 != '0);

	always_comb begin
		wr           = '0;
		wr.en        = v_s2;
		wr.addr      = addr_s2;
		wr.data      = entry_s2;
		wr.data.life = life_s2;
		if (alive) begin
			wr.data.pos_x = entry_s2.pos_x - $signed(step_x[P_W-1:0]);
			wr.data.pos_y = entry_s2.pos_y - $signed(step_y[P_W-1:0]);
			wr.data.alpha = ({1'b0, entry_s2.alpha} > fade) ?
				entry_s2.alpha - Q_W'(fade) : '0;
		end
	end

	assign live = v_s2 && alive;

endmodule

### rtl/particle_pool_update_top.sv
// Particle pool update: sequencer around the slot memory, tick and spawn datapaths.
//
// Input beats arrive on s_axis (tuser = kind: spawn, tick, read, unused);
// each produces exactly one result beat on m_axis. The pool size is set by
// writing cfg_data on the cfg_valid/cfg_ready channel; the user must do so
// only while the block is idle, which the block itself does not enforce. One
// item is in work at a time; s_axis_tready is high only between items. Per kind:
//   read: the slot at the requested index
//   tick: slots 0 to a-1 (a = active slots), one slot read and one written back per cycle
//   spawn: one slot probed per cycle until a free one
// These rates are set by the single read port of the slot memory.
// A result waits in the output register while m_axis_tready is low; the next
// item is accepted meanwhile and holds in its last step until the register
// frees. Reset clears all slots (valid bits, no sweep), sets the pool size to
// 64 and the search start to slot 0.
`include "assert_macros.svh"
module particle_pool_update_top import ppu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// dt, obj_x, obj_y, obj_vx, obj_vy, offset_x, offset_y, jitter, shade, index
	input  logic [IN_W-1:0]  s_axis_tdata,
	// kind
	input  logic [1:0]       s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// slot, live, life_left, pos_x, pos_y, alpha, grey, live_count
	output logic [OUT_W-1:0] m_axis_tdata,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [ACT_W-1:0] cfg_data
);

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_SEARCH    = 7'b0000010,
		ST_SPAWN_WR  = 7'b0000100,
		ST_TICK      = 7'b0001000,
		ST_READ      = 7'b0010000,
		ST_READ_DATA = 7'b0100000,
		ST_RESULT    = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	in_item_t          in_q;
	logic [ACT_W-1:0]  active_count_q;
	logic [CNT_W-1:0]  a_eff;
	logic [ADDR_W-1:0] start_eff;
	logic [SUM_W-1:0]  scan_sum;
	logic [ADDR_W-1:0] scan_addr;
	logic [CNT_W-1:0]  iss_q;
	logic              rd_v_s1;
	logic [ADDR_W-1:0] rd_addr_s1;
	logic [ADDR_W-1:0] slot_q;
	logic [ADDR_W-1:0] search_start_q;
	logic [CNT_W-1:0]  live_cnt_q;
	out_item_t         res_q, res_d, out_q;
	logic              res_ld, out_ld;
	logic              m_valid_q;
	logic              in_fire, cfg_fire;
	logic              issuing, found, search_miss, tick_done;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	entry_t            rd_entry;
	entry_t            spawn_entry;
	store_wr_t         st_wr, tick_wr;
	tick_req_t         tick_req;
	logic              tick_live;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign cfg_fire      = cfg_valid && cfg_ready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, out_q};

	// clamp pool size to 1..POOL_SLOTS
	always_comb begin
		if (active_count_q == '0) begin
			a_eff = CNT_W'(1);
		end else if (32'(active_count_q) > POOL_SLOTS) begin
			a_eff = CNT_W'(POOL_SLOTS);
		end else begin
			a_eff = CNT_W'(active_count_q);
		end
	end

	// probe order: start .. a-1, then wrap to 0 .. start-1
	assign start_eff = (CNT_W'(search_start_q) < a_eff) ? search_start_q : '0;
	assign scan_sum  = SUM_W'(start_eff) + SUM_W'(iss_q);
	assign scan_addr = (scan_sum >= SUM_W'(a_eff)) ?
		ADDR_W'(scan_sum - SUM_W'(a_eff)) : ADDR_W'(scan_sum);

	assign issuing = (state_q == ST_SEARCH || state_q == ST_TICK) && (iss_q < a_eff);
	assign rd_en   = issuing || (state_q == ST_READ);

	always_comb begin
		if (state_q == ST_TICK) begin
			rd_addr = ADDR_W'(iss_q);
		end else if (state_q == ST_READ) begin
			rd_addr = ADDR_W'(in_q.index);
		end else begin
			rd_addr = scan_addr;
		end
	end

	assign found       = (state_q == ST_SEARCH) && rd_v_s1 && (rd_entry.life == '0);
	assign search_miss = (state_q == ST_SEARCH) && !rd_v_s1 && (iss_q == a_eff);
	assign tick_done   = (state_q == ST_TICK) && !rd_v_s1 && !tick_wr.en && (iss_q == a_eff);
	assign out_ld      = (state_q == ST_RESULT) && (!m_valid_q || m_axis_tready);

	assign tick_req.valid = rd_v_s1 && (state_q == ST_TICK);
	assign tick_req.addr  = rd_addr_s1;
	assign tick_req.data  = rd_entry;

	always_comb begin
		if (state_q == ST_SPAWN_WR) begin
			st_wr.en   = 1'b1;
			st_wr.addr = slot_q;
			st_wr.data = spawn_entry;
		end else begin
			st_wr = tick_wr;
		end
	end

	ppu_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr      (st_wr),
		.rd_data (rd_entry)
	);

	ppu_spawn_calc u_spawn (
		.clk   (clk),
		.item  (in_q),
		.entry (spawn_entry)
	);

	ppu_tick_alu u_tick (
		.clk    (clk),
		.arst_n (arst_n),
		.dt     (in_q.dt),
		.req    (tick_req),
		.wr     (tick_wr),
		.live   (tick_live)
	);

	always_comb begin
		state_d = state_q;
		res_ld  = 1'b0;
		res_d   = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (kind_t'(s_axis_tuser))
						KIND_SPAWN: state_d = ST_SEARCH;
						KIND_TICK:  state_d = ST_TICK;
						KIND_READ:  state_d = ST_READ;
						default: begin
							state_d = ST_RESULT;
							res_ld  = 1'b1;
						end
					endcase
				end
			end
			ST_SEARCH: begin
				if (found || search_miss) begin
					state_d = ST_SPAWN_WR;
				end
			end
			ST_SPAWN_WR: begin
				res_ld          = 1'b1;
				res_d.slot      = SLOT_W'(slot_q);
				res_d.live      = 1'b1;
				res_d.life_left = spawn_entry.life;
				res_d.pos_x     = spawn_entry.pos_x;
				res_d.pos_y     = spawn_entry.pos_y;
				res_d.alpha     = spawn_entry.alpha;
				res_d.grey      = spawn_entry.shade;
				state_d         = ST_RESULT;
			end
			ST_TICK: begin
				if (tick_done) begin
					res_ld           = 1'b1;
					res_d.live_count = ACT_W'(live_cnt_q);
					state_d          = ST_RESULT;
				end
			end
			ST_READ: begin
				if (32'(in_q.index) < POOL_SLOTS) begin
					state_d = ST_READ_DATA;
				end else begin
					res_ld     = 1'b1;
					res_d.slot = in_q.index;
					state_d    = ST_RESULT;
				end
			end
			ST_READ_DATA: begin
				res_ld          = 1'b1;
				res_d.slot      = in_q.index;
				res_d.live      = (rd_entry.life != '0);
				res_d.life_left = rd_entry.life;
				res_d.pos_x     = rd_entry.pos_x;
				res_d.pos_y     = rd_entry.pos_y;
				res_d.alpha     = rd_entry.alpha;
				res_d.grey      = rd_entry.shade;
				state_d         = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_ld) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			iss_q          <= '0;
			rd_v_s1        <= 1'b0;
			search_start_q <= '0;
			live_cnt_q     <= '0;
			active_count_q <= ACT_RESET;
			m_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issuing;
			if (in_fire) begin
				iss_q <= '0;
			end else if (issuing) begin
				iss_q <= iss_q + CNT_W'(1);
			end
			if (state_q == ST_SPAWN_WR) begin
				search_start_q <= slot_q;
			end
			if (in_fire) begin
				live_cnt_q <= '0;
			end else if (tick_live) begin
				live_cnt_q <= live_cnt_q + CNT_W'(1);
			end
			if (cfg_fire) begin
				active_count_q <= cfg_data;
			end
			if (out_ld) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			in_q <= in_item_t'(s_axis_tdata[IN_BITS-1:0]);
		end
		rd_addr_s1 <= rd_addr;
		// no free slot: fall back to slot 0
		if (found) begin
			slot_q <= rd_addr_s1;
		end else if (search_miss) begin
			slot_q <= '0;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (out_ld) begin
			out_q <= res_q;
		end
	end

	`ASSERT_AT(a_wr_in_update, !st_wr.en || state_q == ST_SPAWN_WR || state_q == ST_TICK, "store written outside spawn or tick")
	`ASSERT_AT(a_tick_addr, !tick_wr.en || CNT_W'(tick_wr.addr) < a_eff, "tick wrote beyond the active slots")
	`ASSERT_AT(a_out_src, $rose(m_axis_tvalid) |-> $past(state_q == ST_RESULT), "result beat without a finished item")
	`ASSERT_NEXT(a_out_idle, out_ld, state_q == ST_IDLE && m_axis_tvalid, "result load did not free the sequencer")

endmodule
